>>> src/fsp_pkg.sv
// fsp_pkg: shared types, character codes and class functions for the
// format specifier parser. No dependencies.
package fsp_pkg;

	localparam int unsigned ItemDataW = 40;
	localparam int unsigned ResDataW  = 88;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LC    = 8'h63;
	localparam logic [7:0] CH_LS    = 8'h73;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LI    = 8'h69;
	localparam logic [7:0] CH_LU    = 8'h75;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FLAGS  = 3'd1,
		PH_WDIG   = 3'd2,
		PH_AFTW   = 3'd3,
		PH_PSTART = 3'd4,
		PH_PRUN   = 3'd5,
		PH_CONV   = 3'd6
	} fsp_phase_t;

	typedef struct packed {
		fsp_phase_t  phase;
		logic        minus_flag;
		logic        zero_flag;
		logic [30:0] width_acc;
		logic        width_seen;
		logic        prec_seen;
		logic [31:0] prec_acc;
		logic        prec_negative;
		logic        prec_run_stopped;
		logic [7:0]  char_count;
	} fsp_state_t;

	typedef struct packed {
		logic               start_req;
		logic [7:0]         ch;
		logic signed [31:0] star_value;
	} fsp_item_t;

	typedef struct packed {
		logic               error;
		logic               left_justify;
		logic               zero_pad;
		logic               width_given;
		logic [30:0]        min_width;
		logic               has_precision;
		logic signed [31:0] precision_value;
		logic [7:0]         conversion;
		logic [7:0]         spec_length;
	} fsp_result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_flag(input logic [7:0] c);
		return c inside {CH_MINUS, CH_ZERO, CH_PLUS, CH_HASH};
	endfunction

	function automatic logic is_conv(input logic [7:0] c);
		return c inside {CH_LC, CH_LS, CH_LP, CH_LD, CH_LI, CH_LU, CH_LX, CH_UX, CH_PCT};
	endfunction

	function automatic logic is_noz(input logic [7:0] c);
		return c inside {CH_LS, CH_LP, CH_LD, CH_LI, CH_LU, CH_LX, CH_UX};
	endfunction

endpackage

>>> src/fsp_mac.sv
// fsp_mac: saturating decimal accumulate, acc * 10 + digit, clipped at SAT_MAX.
// Depends on fsp_pkg.
module fsp_mac (
	input  logic [31:0] acc,
	input  logic [7:0]  ch,
	output logic [31:0] acc_next
);
	import fsp_pkg::*;

	logic [7:0]  dig_full;
	logic [35:0] sum;

	assign dig_full = ch - CH_ZERO;
	assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, dig_full[3:0]};
	assign acc_next = (sum > {4'd0, SAT_MAX}) ? SAT_MAX : sum[31:0];

endmodule

>>> src/fsp_step.sv
// fsp_step: next state and result for one specifier character.
// Depends on fsp_pkg and fsp_mac.
module fsp_step (
	input  fsp_pkg::fsp_state_t  cur,
	input  fsp_pkg::fsp_item_t   item,
	output fsp_pkg::fsp_state_t  nxt,
	output logic                 res_valid,
	output fsp_pkg::fsp_result_t res
);
	import fsp_pkg::*;

	logic [31:0] mac_op;
	logic [31:0] mac_out;
	logic [31:0] neg_star;
	logic [7:0]  dig_full;

	assign mac_op = (cur.phase == PH_WDIG) ? {1'b0, cur.width_acc} : cur.prec_acc;
	assign neg_star = ~item.star_value + 32'd1;
	assign dig_full = item.ch - CH_ZERO;

	fsp_mac u_mac (
		.acc      (mac_op),
		.ch       (item.ch),
		.acc_next (mac_out)
	);

	always_comb begin
		fsp_state_t st;
		logic       done;
		logic       c_dig;
		logic       z;
		st = cur;
		done = 1'b0;
		c_dig = is_digit(item.ch);
		z = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (item.start_req) begin
			st = '0;
			st.phase = PH_FLAGS;
			st.char_count = 8'd1;
			done = 1'b1;
		end else if (cur.phase == PH_IDLE) begin
			done = 1'b1;
		end else if (cur.char_count != 8'hFF) begin
			st.char_count = cur.char_count + 8'd1;
		end

		if (!done && st.phase == PH_FLAGS) begin
			if (is_flag(item.ch)) begin
				if (item.ch == CH_MINUS) st.minus_flag = 1'b1;
				if (item.ch == CH_ZERO) st.zero_flag = 1'b1;
				done = 1'b1;
			end else if (item.ch == CH_STAR) begin
				if (item.star_value[31]) begin
					st.width_acc = neg_star[31] ? SAT_MAX[30:0] : neg_star[30:0];
					st.minus_flag = 1'b1;
				end else begin
					st.width_acc = item.star_value[30:0];
				end
				st.width_seen = 1'b1;
				st.phase = PH_AFTW;
				done = 1'b1;
			end else if (c_dig) begin
				st.width_acc = {27'd0, dig_full[3:0]};
				st.width_seen = 1'b1;
				st.phase = PH_WDIG;
				done = 1'b1;
			end else begin
				st.phase = PH_AFTW;
			end
		end

		if (!done && st.phase == PH_WDIG) begin
			if (c_dig) begin
				st.width_acc = mac_out[30:0];
				done = 1'b1;
			end else begin
				st.phase = PH_AFTW;
			end
		end

		if (!done && st.phase == PH_AFTW) begin
			if (item.ch == CH_DOT) begin
				st.prec_seen = 1'b1;
				st.prec_acc = '0;
				st.phase = PH_PSTART;
				done = 1'b1;
			end else begin
				st.phase = PH_CONV;
			end
		end

		if (!done && st.phase == PH_PSTART) begin
			if (item.ch == CH_STAR) begin
				st.prec_acc = item.star_value;
				st.phase = PH_CONV;
				done = 1'b1;
			end else if (item.ch == CH_MINUS || c_dig) begin
				st.prec_negative = (item.ch == CH_MINUS);
				st.prec_acc = c_dig ? {28'd0, dig_full[3:0]} : 32'd0;
				st.prec_run_stopped = 1'b0;
				st.phase = PH_PRUN;
				done = 1'b1;
			end else begin
				st.prec_acc = '0;
				st.phase = PH_CONV;
			end
		end

		if (!done && st.phase == PH_PRUN) begin
			if (c_dig) begin
				if (!st.prec_run_stopped) st.prec_acc = mac_out;
				done = 1'b1;
			end else if (item.ch == CH_MINUS) begin
				st.prec_run_stopped = 1'b1;
				done = 1'b1;
			end else begin
				if (st.prec_negative && st.prec_acc != 32'd0) begin
					st.width_acc = st.prec_acc[30:0];
					st.width_seen = 1'b1;
					st.minus_flag = 1'b1;
				end
				if (st.prec_negative) st.prec_acc = '0;
				st.phase = PH_CONV;
			end
		end

		// any character not taken above closes the specifier; one that is not a conversion character is an error
		if (!done) begin
			st.phase = PH_IDLE;
			res_valid = 1'b1;
			res.spec_length = st.char_count;
			if (!is_conv(item.ch)) begin
				res.error = 1'b1;
			end else begin
				z = st.zero_flag && !st.minus_flag;
				if (z && st.prec_seen && !st.prec_acc[31] && is_noz(item.ch)) z = 1'b0;
				res.left_justify = st.minus_flag;
				res.zero_pad = z;
				res.width_given = st.width_seen;
				res.min_width = st.width_seen ? st.width_acc : 31'd0;
				res.has_precision = st.prec_seen;
				res.precision_value = st.prec_seen ? st.prec_acc : 32'hFFFF_FFFF;
				res.conversion = item.ch;
			end
		end

		nxt = st;
	end

endmodule

>>> src/format_specifier_parser_top.sv
// format_specifier_parser_top: input register, parse step and result register.
// Depends on fsp_pkg and fsp_step.
// a closing request passes the input register, then its result the result register
// throughput: one request per cycle while the result side keeps up
// the input register doubles as the skid stage when the result side stalls
// reset: arst_n clears valid flags and parser state to idle; payload is not reset
module format_specifier_parser_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [fsp_pkg::ItemDataW-1:0] s_axis_tdata,   // ch, star_value
	input  logic                          s_axis_tuser,   // start_req
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [fsp_pkg::ResDataW-1:0]  m_axis_tdata,   // left_justify, zero_pad,
	                                                      // width_given, min_width,
	                                                      // has_precision, precision_value,
	                                                      // conversion, spec_length,
	                                                      // zero fill
	output logic                          m_axis_tuser    // error
);
	import fsp_pkg::*;

	logic        item_valid_s1;
	fsp_item_t   item_s1;
	fsp_state_t  state_q;
	fsp_state_t  state_nxt;
	logic        step_res_valid;
	fsp_result_t step_res;
	logic        out_valid_q;
	fsp_result_t out_q;
	logic        adv;
	logic        in_fire;

	assign adv = item_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || adv;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]};
		end
	end

	fsp_step u_step (
		.cur       (state_q),
		.item      (item_s1),
		.nxt       (state_nxt),
		.res_valid (step_res_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && step_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_res_valid) begin
			out_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.error;
	assign m_axis_tdata  = {5'd0, out_q.spec_length, out_q.conversion, out_q.precision_value,
		out_q.has_precision, out_q.min_width, out_q.width_given, out_q.zero_pad,
		out_q.left_justify};

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !adv |=> item_valid_s1 && $stable(item_s1))
		else $error("held request changed while stalled");

	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv) && $past(step_res_valid))
		else $error("result appeared without a closing request");

	a_count_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != PH_IDLE |-> state_q.char_count != 8'd0)
		else $error("open specifier with zero length");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[74:0] == 75'd0)
		else $error("error result carries payload");

	a_no_stall_loss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");
`endif

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for format_specifier_parser_top, streams printf
// specifiers character by character and checks every parse result against a local model or a table entry
// depends on fsp_pkg and the format_specifier_parser_top rtl
`timescale 1ns / 100ps

module tb;
	import fsp_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LZ  = 8'h7A;
	localparam int unsigned CHAR_TARGET = 850;

	typedef struct {
		fsp_item_t   item;
		bit          typed;
		fsp_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tuser;

	// parser state as the model sees it
	fsp_phase_t  ph      = PH_IDLE;
	logic        f_minus = 1'b0;
	logic        f_zero  = 1'b0;
	logic [30:0] w_acc   = '0;
	logic        w_seen  = 1'b0;
	logic        p_seen  = 1'b0;
	logic [31:0] p_acc   = '0;
	logic        p_neg   = 1'b0;
	logic        p_stop  = 1'b0;
	logic [7:0]  n_chars = '0;

	fsp_result_t pending_specs[$];
	stim_row_t   stim_rows[$];
	fsp_item_t   spec_chars[$];

	int unsigned chars_parsed = 0;
	int unsigned specs_closed = 0;
	int unsigned bad_specs    = 0;
	int unsigned longest_spec = 0;
	int unsigned mismatches   = 0;
	int unsigned sink_hold    = 0;
	int unsigned drain_cycles;
	bit          calm = 1'b0;
	bit          long_done = 1'b0;

	format_specifier_parser_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("watchdog expired at %0t", $time);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit dec_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit conv_letter(input logic [7:0] c);
		case (c)
			CH_LC, CH_LS, CH_LP, CH_LD, CH_LI, CH_LU, CH_LX, CH_UX, CH_PCT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [30:0] sat_mac10(input logic [30:0] acc, input logic [7:0] c);
		logic [35:0] v;
		v = {5'd0, acc} * 36'd10 + {28'd0, c - CH_ZERO};
		return (v > {4'd0, SAT_MAX}) ? SAT_MAX[30:0] : v[30:0];
	endfunction

	// advances the parser by one character; returns 1 when a specifier closes
	function automatic bit parse_char(input logic start, input logic [7:0] c,
			input logic [31:0] sv, output fsp_result_t res);
		logic [31:0] mag;
		logic        zp;
		res = '0;
		if (start) begin
			ph      = PH_FLAGS;
			f_minus = 1'b0;
			f_zero  = 1'b0;
			w_acc   = '0;
			w_seen  = 1'b0;
			p_seen  = 1'b0;
			p_acc   = '0;
			p_neg   = 1'b0;
			p_stop  = 1'b0;
			n_chars = 8'd1;
			return 1'b0;
		end
		if (ph == PH_IDLE)
			return 1'b0;
		if (n_chars != 8'd255)
			n_chars++;
		if (ph == PH_FLAGS) begin
			if (c == CH_MINUS || c == CH_ZERO || c == CH_PLUS || c == CH_HASH) begin
				if (c == CH_MINUS)
					f_minus = 1'b1;
				if (c == CH_ZERO)
					f_zero = 1'b1;
				return 1'b0;
			end
			if (c == CH_STAR) begin
				if (sv[31]) begin
					mag     = -sv;
					w_acc   = (mag > SAT_MAX) ? SAT_MAX[30:0] : mag[30:0];
					f_minus = 1'b1;
				end else begin
					w_acc = sv[30:0];
				end
				w_seen = 1'b1;
				ph     = PH_AFTW;
				return 1'b0;
			end
			if (dec_digit(c)) begin
				w_acc  = {23'd0, c - CH_ZERO};
				w_seen = 1'b1;
				ph     = PH_WDIG;
				return 1'b0;
			end
			ph = PH_AFTW;
		end
		if (ph == PH_WDIG) begin
			if (dec_digit(c)) begin
				w_acc = sat_mac10(w_acc, c);
				return 1'b0;
			end
			ph = PH_AFTW;
		end
		if (ph == PH_AFTW) begin
			if (c == CH_DOT) begin
				p_seen = 1'b1;
				p_acc  = '0;
				ph     = PH_PSTART;
				return 1'b0;
			end
			ph = PH_CONV;
		end
		if (ph == PH_PSTART) begin
			if (c == CH_STAR) begin
				p_acc = sv;
				ph    = PH_CONV;
				return 1'b0;
			end
			if (c == CH_MINUS || dec_digit(c)) begin
				p_neg  = (c == CH_MINUS);
				p_acc  = dec_digit(c) ? {24'd0, c - CH_ZERO} : 32'd0;
				p_stop = 1'b0;
				ph     = PH_PRUN;
				return 1'b0;
			end
			p_acc = '0;
			ph    = PH_CONV;
		end
		if (ph == PH_PRUN) begin
			if (dec_digit(c)) begin
				if (!p_stop)
					p_acc = {1'b0, sat_mac10(p_acc[30:0], c)};
				return 1'b0;
			end
			if (c == CH_MINUS) begin
				p_stop = 1'b1;
				return 1'b0;
			end
			if (p_neg && p_acc != 0) begin
				w_acc   = p_acc[30:0];
				w_seen  = 1'b1;
				f_minus = 1'b1;
			end
			if (p_neg)
				p_acc = '0;
			ph = PH_CONV;
		end
		// this character closes the specifier
		ph = PH_IDLE;
		res.spec_length = n_chars;
		if (!conv_letter(c)) begin
			res.error = 1'b1;
			return 1'b1;
		end
		zp = f_zero && !f_minus;
		if (zp && p_seen && !p_acc[31] && c != CH_LC && c != CH_PCT)
			zp = 1'b0;
		res.left_justify    = f_minus;
		res.zero_pad        = zp;
		res.width_given     = w_seen;
		res.min_width       = w_seen ? w_acc : 31'd0;
		res.has_precision   = p_seen;
		res.precision_value = p_seen ? p_acc : 32'hFFFF_FFFF;
		res.conversion      = c;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap(input bit may_skip);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (may_skip && r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_star();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 20)) :
				-32'($urandom_range(1, 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_flag();
		case ($urandom_range(0, 3))
			0: return CH_MINUS;
			1: return CH_ZERO;
			2: return CH_PLUS;
			default: return CH_HASH;
		endcase
	endfunction

	function automatic logic [7:0] rand_conv();
		case ($urandom_range(0, 8))
			0: return CH_LC;
			1: return CH_LS;
			2: return CH_LP;
			3: return CH_LD;
			4: return CH_LI;
			5: return CH_LU;
			6: return CH_LX;
			7: return CH_UX;
			default: return CH_PCT;
		endcase
	endfunction

	task automatic push_ch(input logic s, input logic [7:0] c, input logic [31:0] sv);
		fsp_item_t it;
		it.start_req  = s;
		it.ch         = c;
		it.star_value = sv;
		spec_chars.push_back(it);
	endtask

	task automatic table_row(input logic s, input logic [7:0] c, input logic [31:0] sv,
			input bit typed, input fsp_result_t want);
		stim_row_t row;
		row.item.start_req  = s;
		row.item.ch         = c;
		row.item.star_value = sv;
		row.typed           = typed;
		row.want            = want;
		stim_rows.push_back(row);
	endtask

	// one request; prediction happens at the accepting edge
	task automatic send_item(input fsp_item_t it, input bit typed, input fsp_result_t want);
		int unsigned gap;
		fsp_result_t res;
		gap = calm ? 0 : pick_gap(1'b1);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.start_req;
		s_axis_tdata  <= {it.star_value, it.ch};
		do @(posedge clk); while (!s_axis_tready);
		if (it.start_req || ph != PH_IDLE)
			chars_parsed++;
		if (parse_char(it.start_req, it.ch, it.star_value, res))
			pending_specs.push_back(typed ? want : res);
	endtask

	task automatic build_spec(input bit broken, input bit long_run);
		int unsigned n;
		int unsigned r;
		int unsigned cut;
		spec_chars.delete();
		push_ch(1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom) : CH_PCT, rand_star());
		n = $urandom_range(0, 5);
		if (n > 3)
			n = 0;
		repeat (n) push_ch(1'b0, rand_flag(), rand_star());
		r = $urandom_range(0, 9);
		if (long_run) begin
			repeat (300) push_ch(1'b0, rand_digit(), rand_star());
		end else if (r >= 5) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 3);
			repeat (n) push_ch(1'b0, rand_digit(), rand_star());
		end else if (r >= 3) begin
			push_ch(1'b0, CH_STAR, rand_star());
		end
		if ($urandom_range(0, 1)) begin
			push_ch(1'b0, CH_DOT, rand_star());
			case ($urandom_range(0, 3))
				0: push_ch(1'b0, CH_STAR, rand_star());
				1: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 3);
					repeat (n) push_ch(1'b0, rand_digit(), rand_star());
				end
				2: begin
					push_ch(1'b0, CH_MINUS, rand_star());
					repeat ($urandom_range(0, 5))
						push_ch(1'b0, ($urandom_range(0, 4) == 0) ? CH_MINUS : rand_digit(),
							rand_star());
				end
				default: ;
			endcase
		end
		r = $urandom_range(0, 19);
		if (r == 0)
			push_ch(1'b0, CH_NUL, rand_star());
		else if (r < 3)
			push_ch(1'b0, 8'($urandom), rand_star());
		else
			push_ch(1'b0, rand_conv(), rand_star());
		if (broken) begin
			cut = $urandom_range(1, spec_chars.size() - 1);
			while (spec_chars.size() > cut)
				void'(spec_chars.pop_back());
			if ($urandom_range(0, 1))
				push_ch(1'b0, 8'($urandom), rand_star());
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result sink with random back-pressure
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (calm || $urandom_range(0, 2) != 0) begin
			m_axis_tready <= 1'b1;
			sink_hold     <= calm ? 0 : $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b0;
			sink_hold     <= pick_gap(1'b0);
		end
	end

	always @(posedge clk) begin
		fsp_result_t want;
		fsp_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.error           = m_axis_tuser;
			got.left_justify    = m_axis_tdata[0];
			got.zero_pad        = m_axis_tdata[1];
			got.width_given     = m_axis_tdata[2];
			got.min_width       = m_axis_tdata[33:3];
			got.has_precision   = m_axis_tdata[34];
			got.precision_value = m_axis_tdata[66:35];
			got.conversion      = m_axis_tdata[74:67];
			got.spec_length     = m_axis_tdata[82:75];
			specs_closed++;
			if (got.error)
				bad_specs++;
			if (got.spec_length > longest_spec)
				longest_spec = got.spec_length;
			if (pending_specs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h / %b", $time,
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_specs.pop_front();
				check_field("error", want.error, got.error);
				check_field("left_justify", want.left_justify, got.left_justify);
				check_field("zero_pad", want.zero_pad, got.zero_pad);
				check_field("width_given", want.width_given, got.width_given);
				check_field("min_width", want.min_width, got.min_width);
				check_field("has_precision", want.has_precision, got.has_precision);
				check_field("precision_value", want.precision_value, got.precision_value);
				check_field("conversion", want.conversion, got.conversion);
				check_field("spec_length", want.spec_length, got.spec_length);
				check_field("zero fill", 32'd0, m_axis_tdata[87:83]);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;

		// idle character, plain %d, end-of-string, bad letter
		table_row(1'b0, CH_LD, 32'd0, 1'b0, '0);
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_LD, 32'd0, 1'b1,
			'{1'b0, 1'b0, 1'b0, 1'b0, 31'd0, 1'b0, -32'sd1, CH_LD, 8'd2});
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_NUL, 32'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, 1'b0, 31'd0, 1'b0, 32'sd0, 8'd0, 8'd2});
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO + 8'd5, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_DOT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_LZ, 32'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, 1'b0, 31'd0, 1'b0, 32'sd0, 8'd0, 8'd4});
		// all flags, most negative star width, negative star precision
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_MINUS, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_PLUS, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_HASH, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_STAR, 32'h8000_0000, 1'b0, '0);
		table_row(1'b0, CH_DOT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_STAR, -32'd5, 1'b0, '0);
		table_row(1'b0, CH_UX, 32'hFFFF_FFFF, 1'b0, '0);
		// negative literal precision with a second minus
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_DOT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_MINUS, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO + 8'd7, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_MINUS, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO + 8'd9, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_LU, 32'd0, 1'b0, '0);
		// restart mid-spec, then bare point on i and on c
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO + 8'd4, 32'd0, 1'b0, '0);
		table_row(1'b1, CH_LX, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_DOT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_LI, 32'd0, 1'b0, '0);
		table_row(1'b1, CH_PCT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_ZERO, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_DOT, 32'd0, 1'b0, '0);
		table_row(1'b0, CH_LC, 32'd0, 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[k])
			send_item(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);

		while (chars_parsed < CHAR_TARGET) begin
			calm <= ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 19) == 0) begin
				spec_chars.delete();
				repeat ($urandom_range(1, 4))
					push_ch(($urandom_range(0, 9) == 0), 8'($urandom), $urandom);
			end else if (!long_done && chars_parsed > 300) begin
				build_spec(1'b0, 1'b1);
				long_done = 1'b1;
			end else begin
				build_spec(($urandom_range(0, 7) == 0), 1'b0);
			end
			foreach (spec_chars[k])
				send_item(spec_chars[k], 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		drain_cycles = 0;
		while (pending_specs.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_specs.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_specs.size());
			mismatches += pending_specs.size();
		end

		$display("parsed %0d characters into %0d specifiers, %0d of them rejected",
			chars_parsed, specs_closed, bad_specs);
		$display("longest specifier %0d characters, %0d mismatches", longest_spec, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/fsp_pkg.sv
src/fsp_mac.sv
src/fsp_step.sv
src/format_specifier_parser_top.sv
tb/tb.sv
